/* rtl/egmea_pkg.sv */
// shared types and constants for the event grouped mean and error accumulator
// no dependencies; every other file of the block uses this package
`timescale 1ns / 1ps
`default_nettype none

package egmea_pkg;

	localparam int CMD_W   = 2;
	localparam int TOTAL_W = 64;
	localparam int EVSUM_W = 48;
	localparam int COUNT_W = 32;
	localparam int WIDE_W  = 128;

	localparam int DIV_STEPS  = WIDE_W;
	localparam int SQRT_STEPS = WIDE_W / 2;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ENTRY,
		S_SQ_MUL,
		S_Q_MEAN_START,
		S_Q_MEAN_DIV,
		S_Q_MEAN_SET,
		S_Q_ERR_START,
		S_Q_NN_MUL,
		S_Q_N3_MUL,
		S_Q_A_MUL,
		S_Q_B_MUL,
		S_Q_CHECK,
		S_Q_ERR_DIV,
		S_Q_SQRT_LOAD,
		S_Q_SQRT,
		S_Q_ERR_SET,
		S_Q_OUT
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_CLEAR,
		OP_ENTRY,
		OP_MUL_STEP,
		OP_CLOSE,
		OP_MEAN_LOAD,
		OP_MEAN_RAW,
		OP_DIV_STEP,
		OP_MEAN_SET,
		OP_ERR_RAW,
		OP_NN_LOAD,
		OP_N3_LOAD,
		OP_A_LOAD,
		OP_B_LOAD,
		OP_SUB,
		OP_ERR_ZERO,
		OP_ERR_DIV_LOAD,
		OP_SQRT_LOAD,
		OP_SQRT_STEP,
		OP_ERR_SET,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		logic is_new;
		logic mul_done;
		logic n_zero;
		logic n_small;
		logic diff_pos;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

/* rtl/egmea_in_if.sv */
// input channel: command, event id and weight with valid/ready
// depends on egmea_pkg for the command width
`timescale 1ns / 1ps
`default_nettype none

interface egmea_in_if #(
	parameter int ID_WIDTH     = 32,
	parameter int WEIGHT_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic [egmea_pkg::CMD_W-1:0]    cmd;
	logic [ID_WIDTH-1:0]            event_id;
	logic signed [WEIGHT_WIDTH-1:0] weight;

	modport source (output valid, cmd, event_id, weight, input ready);
	modport sink (input valid, cmd, event_id, weight, output ready);
endinterface

`default_nettype wire

/* rtl/egmea_out_if.sv */
// result channel: mean, error and event count with valid/ready
// depends on egmea_pkg for the count width
`timescale 1ns / 1ps
`default_nettype none

interface egmea_out_if #(
	parameter int WEIGHT_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [WEIGHT_WIDTH-1:0] mean_value;
	logic signed [WEIGHT_WIDTH-1:0] error_value;
	logic [egmea_pkg::COUNT_W-1:0]  events_seen;

	modport source (output valid, mean_value, error_value, events_seen, input ready);
	modport sink (input valid, mean_value, error_value, events_seen, output ready);
endinterface

`default_nettype wire

/* rtl/event_grouped_mean_error_accumulator_top.sv */
// Event grouped mean and standard error accumulator. An entry is captured and
// then added in; no new item is taken until the block is idle again. An entry
// that opens a new event also squares the finished event's sum on a shift-add
// multiplier, stepping once per significant bit of that sum, then folds the
// square into the sum of squares. A query runs a 128-step restoring divide for
// the mean (skipped with no events), four shift-add products of up to 64 steps,
// a second 128-step divide and a 64-step square root, all on one shared 128-bit
// add/compare datapath; the products and all after them are skipped with two
// events or fewer, the last divide and root when the difference is not positive.
// A query waits for the output register to empty. The result sits in an output
// register, so the next item is taken while it waits to be transferred.
// depends on egmea_pkg, egmea_in_if, egmea_out_if, egmea_ctrl and egmea_dp
`timescale 1ns / 1ps
`default_nettype none

module event_grouped_mean_error_accumulator_top #(
	parameter int WEIGHT_WIDTH  = 24,
	parameter int FRACTION_BITS = 16,
	parameter int ID_WIDTH      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	egmea_in_if.sink    in_ch,
	egmea_out_if.source out_ch
);
	import egmea_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	egmea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_ready (in_ch.ready),
		.status   (status),
		.op       (op)
	);

	egmea_dp #(
		.WEIGHT_WIDTH  (WEIGHT_WIDTH),
		.FRACTION_BITS (FRACTION_BITS),
		.ID_WIDTH      (ID_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.in_event_id (in_ch.event_id),
		.in_weight   (in_ch.weight),
		.status      (status),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_mean    (out_ch.mean_value),
		.out_error   (out_ch.error_value),
		.out_events  (out_ch.events_seen)
	);

endmodule

`default_nettype wire

/* rtl/egmea_ctrl.sv */
// sequencing state machine: decodes commands and steps the datapath
// depends on egmea_pkg
`timescale 1ns / 1ps
`default_nettype none

module egmea_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [egmea_pkg::CMD_W-1:0] in_cmd,
	output logic                        in_ready,
	input  egmea_pkg::dp_status_t       status,
	output egmea_pkg::dp_op_t           op
);
	import egmea_pkg::*;

	ctrl_state_t         state_q, state_d;
	logic [STEP_W-1:0]   cnt_q;
	logic                accept;
	logic                div_last, sqrt_last;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_last  = (cnt_q == STEP_W'(DIV_STEPS - 1));
	assign sqrt_last = (cnt_q == STEP_W'(SQRT_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_Q_MEAN_DIV || state_q == S_Q_ERR_DIV || state_q == S_Q_SQRT) begin
				cnt_q <= cnt_q + STEP_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_ADD:   state_d = S_ENTRY;
						CMD_QUERY: state_d = S_Q_MEAN_START;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ENTRY:        state_d = status.is_new ? S_SQ_MUL : S_IDLE;
			S_SQ_MUL:       if (status.mul_done) state_d = S_IDLE;
			S_Q_MEAN_START: state_d = status.n_zero ? S_Q_ERR_START : S_Q_MEAN_DIV;
			S_Q_MEAN_DIV:   if (div_last) state_d = S_Q_MEAN_SET;
			S_Q_MEAN_SET:   state_d = S_Q_ERR_START;
			S_Q_ERR_START:  state_d = status.n_small ? S_Q_OUT : S_Q_NN_MUL;
			S_Q_NN_MUL:     if (status.mul_done) state_d = S_Q_N3_MUL;
			S_Q_N3_MUL:     if (status.mul_done) state_d = S_Q_A_MUL;
			S_Q_A_MUL:      if (status.mul_done) state_d = S_Q_B_MUL;
			S_Q_B_MUL:      if (status.mul_done) state_d = S_Q_CHECK;
			S_Q_CHECK:      state_d = status.diff_pos ? S_Q_ERR_DIV : S_Q_OUT;
			S_Q_ERR_DIV:    if (div_last) state_d = S_Q_SQRT_LOAD;
			S_Q_SQRT_LOAD:  state_d = S_Q_SQRT;
			S_Q_SQRT:       if (sqrt_last) state_d = S_Q_ERR_SET;
			S_Q_ERR_SET:    state_d = S_Q_OUT;
			S_Q_OUT:        if (!status.out_busy) state_d = S_IDLE;
			default:        state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_cmd)
						CMD_ADD:   op = OP_CAPTURE;
						CMD_CLEAR: op = OP_CLEAR;
						default:   op = OP_NONE;
					endcase
				end
			end
			S_ENTRY:        op = OP_ENTRY;
			S_SQ_MUL:       op = status.mul_done ? OP_CLOSE : OP_MUL_STEP;
			S_Q_MEAN_START: op = status.n_zero ? OP_MEAN_RAW : OP_MEAN_LOAD;
			S_Q_MEAN_DIV:   op = OP_DIV_STEP;
			S_Q_MEAN_SET:   op = OP_MEAN_SET;
			S_Q_ERR_START:  op = status.n_small ? OP_ERR_RAW : OP_NN_LOAD;
			S_Q_NN_MUL:     op = status.mul_done ? OP_N3_LOAD : OP_MUL_STEP;
			S_Q_N3_MUL:     op = status.mul_done ? OP_A_LOAD : OP_MUL_STEP;
			S_Q_A_MUL:      op = status.mul_done ? OP_B_LOAD : OP_MUL_STEP;
			S_Q_B_MUL:      op = status.mul_done ? OP_SUB : OP_MUL_STEP;
			S_Q_CHECK:      op = status.diff_pos ? OP_ERR_DIV_LOAD : OP_ERR_ZERO;
			S_Q_ERR_DIV:    op = OP_DIV_STEP;
			S_Q_SQRT_LOAD:  op = OP_SQRT_LOAD;
			S_Q_SQRT:       op = OP_SQRT_STEP;
			S_Q_ERR_SET:    op = OP_ERR_SET;
			S_Q_OUT:        op = status.out_busy ? OP_NONE : OP_OUT_LOAD;
			default:        op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/egmea_dp.sv */
// datapath: statistics registers, shift-add multiplier, restoring divider,
// bit-pair square root on one 128-bit working set, and the result register
// depends on egmea_pkg
`timescale 1ns / 1ps
`default_nettype none

module egmea_dp #(
	parameter int WEIGHT_WIDTH  = 24,
	parameter int FRACTION_BITS = 16,
	parameter int ID_WIDTH      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  egmea_pkg::dp_op_t               op,
	input  logic [ID_WIDTH-1:0]             in_event_id,
	input  logic signed [WEIGHT_WIDTH-1:0]  in_weight,
	output egmea_pkg::dp_status_t           status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [WEIGHT_WIDTH-1:0]  out_mean,
	output logic signed [WEIGHT_WIDTH-1:0]  out_error,
	output logic [egmea_pkg::COUNT_W-1:0]   out_events
);
	import egmea_pkg::*;

	localparam logic [TOTAL_W-1:0] OUT_MAX_MAG =
		(TOTAL_W'(1) << (WEIGHT_WIDTH - 1)) - TOTAL_W'(1);

	// statistics
	logic signed [TOTAL_W-1:0] wtot_q;
	logic [TOTAL_W-1:0]        sqtot_q;
	logic signed [EVSUM_W-1:0] evsum_q;
	logic [COUNT_W-1:0]        count_q;
	logic [ID_WIDTH-1:0]       prev_id_q;
	logic                      prev_ok_q;

	// captured entry and working set
	logic [ID_WIDTH-1:0]            id_q;
	logic signed [WEIGHT_WIDTH-1:0] wt_q;
	logic [WIDE_W-1:0]              r_a_q, r_b_q, r_c_q, n3_q, ab_q;
	logic                           diff_pos_q;
	logic [WEIGHT_WIDTH-1:0]        mean_q, err_q;

	logic                            out_valid_q;
	logic [WEIGHT_WIDTH-1:0]         out_mean_q, out_err_q;
	logic [COUNT_W-1:0]              out_events_q;

	logic signed [TOTAL_W-1:0] wt_ext;
	logic [TOTAL_W:0]          tot_sum;
	logic [TOTAL_W-1:0]        tot_next;
	logic [EVSUM_W:0]          ev_sum;
	logic [EVSUM_W-1:0]        ev_next;
	logic [EVSUM_W-1:0]        evsum_mag;
	logic [TOTAL_W-1:0]        tot_mag;
	logic [WIDE_W-1:0]         sq_shift;
	logic [TOTAL_W:0]          sq_add;
	logic [TOTAL_W-1:0]        sq_next;
	logic                      is_new;
	logic [WIDE_W-1:0]         rem_sh;
	logic                      div_ge;
	logic [WIDE_W-1:0]         sqrt_t;
	logic                      sqrt_ge;

	function automatic logic [WEIGHT_WIDTH-1:0] sat_mag(
		input logic [TOTAL_W-1:0] mag,
		input logic               neg
	);
		logic [TOTAL_W-1:0] r;
		if (neg) begin
			r = (mag > OUT_MAX_MAG) ? ~OUT_MAX_MAG : (TOTAL_W'(0) - mag);
		end else begin
			r = (mag > OUT_MAX_MAG) ? OUT_MAX_MAG : mag;
		end
		return r[WEIGHT_WIDTH-1:0];
	endfunction

	assign wt_ext  = TOTAL_W'(wt_q);
	assign tot_sum = {wtot_q[TOTAL_W-1], wtot_q} + {wt_ext[TOTAL_W-1], wt_ext};
	assign tot_next = (tot_sum[TOTAL_W] != tot_sum[TOTAL_W-1]) ?
		(tot_sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}}) :
		tot_sum[TOTAL_W-1:0];

	assign ev_sum = {evsum_q[EVSUM_W-1], evsum_q} + (EVSUM_W+1)'(wt_q);
	assign ev_next = (ev_sum[EVSUM_W] != ev_sum[EVSUM_W-1]) ?
		(ev_sum[EVSUM_W] ? {1'b1, {(EVSUM_W-1){1'b0}}} : {1'b0, {(EVSUM_W-1){1'b1}}}) :
		ev_sum[EVSUM_W-1:0];

	assign evsum_mag = evsum_q[EVSUM_W-1] ? (EVSUM_W'(0) - evsum_q) : evsum_q;
	assign tot_mag   = wtot_q[TOTAL_W-1] ? (TOTAL_W'(0) - wtot_q) : wtot_q;

	// closed event square back in the weight format, saturating sum
	assign sq_shift = r_c_q >> FRACTION_BITS;
	assign sq_add   = {1'b0, sqtot_q} + {1'b0, sq_shift[TOTAL_W-1:0]};
	assign sq_next  = ((|sq_shift[WIDE_W-1:TOTAL_W]) || sq_add[TOTAL_W]) ?
		{TOTAL_W{1'b1}} : sq_add[TOTAL_W-1:0];

	assign is_new = !prev_ok_q || (id_q != prev_id_q);

	// divider: r_a numerator shifting into quotient, r_b divisor, r_c remainder
	assign rem_sh = {r_c_q[WIDE_W-2:0], r_a_q[WIDE_W-1]};
	assign div_ge = (rem_sh >= r_b_q);

	// square root: r_a radicand, r_b bit, r_c result
	assign sqrt_t  = r_c_q + r_b_q;
	assign sqrt_ge = (r_a_q >= sqrt_t);

	assign status.is_new   = is_new;
	assign status.mul_done = (r_b_q == '0);
	assign status.n_zero   = (count_q == '0);
	assign status.n_small  = (count_q <= COUNT_W'(2));
	assign status.diff_pos = diff_pos_q;
	assign status.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wtot_q    <= '0;
			sqtot_q   <= '0;
			evsum_q   <= '0;
			count_q   <= '0;
			prev_id_q <= '0;
			prev_ok_q <= 1'b0;
		end else begin
			case (op)
				OP_CLEAR: begin
					wtot_q    <= '0;
					sqtot_q   <= '0;
					evsum_q   <= '0;
					count_q   <= '0;
					prev_id_q <= '0;
					prev_ok_q <= 1'b0;
				end
				OP_ENTRY: begin
					wtot_q <= tot_next;
					if (is_new) begin
						prev_id_q <= id_q;
						prev_ok_q <= 1'b1;
						if (count_q != {COUNT_W{1'b1}}) count_q <= count_q + COUNT_W'(1);
					end else begin
						evsum_q <= ev_next;
					end
				end
				OP_CLOSE: begin
					sqtot_q <= sq_next;
					evsum_q <= EVSUM_W'(wt_q);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				id_q <= in_event_id;
				wt_q <= in_weight;
			end
			OP_ENTRY: begin
				r_a_q <= WIDE_W'(evsum_mag);
				r_b_q <= WIDE_W'(evsum_mag);
				r_c_q <= '0;
			end
			OP_MUL_STEP: begin
				if (r_b_q[0]) r_c_q <= r_c_q + r_a_q;
				r_a_q <= r_a_q << 1;
				r_b_q <= r_b_q >> 1;
			end
			OP_MEAN_LOAD: begin
				r_a_q <= WIDE_W'(tot_mag);
				r_b_q <= WIDE_W'(count_q);
				r_c_q <= '0;
			end
			OP_MEAN_RAW: mean_q <= sat_mag(tot_mag, wtot_q[TOTAL_W-1]);
			OP_DIV_STEP: begin
				if (div_ge) begin
					r_c_q <= rem_sh - r_b_q;
					r_a_q <= {r_a_q[WIDE_W-2:0], 1'b1};
				end else begin
					r_c_q <= rem_sh;
					r_a_q <= {r_a_q[WIDE_W-2:0], 1'b0};
				end
			end
			OP_MEAN_SET: mean_q <= sat_mag(r_a_q[TOTAL_W-1:0], wtot_q[TOTAL_W-1]);
			OP_ERR_RAW:  err_q <= sat_mag(tot_mag, wtot_q[TOTAL_W-1]);
			OP_NN_LOAD: begin
				r_a_q <= WIDE_W'(count_q);
				r_b_q <= WIDE_W'(count_q);
				r_c_q <= '0;
			end
			OP_N3_LOAD: begin
				r_a_q <= r_c_q;
				r_b_q <= WIDE_W'(count_q);
				r_c_q <= '0;
			end
			OP_A_LOAD: begin
				n3_q  <= r_c_q;
				r_a_q <= WIDE_W'(count_q);
				r_b_q <= WIDE_W'(sqtot_q);
				r_c_q <= '0;
			end
			OP_B_LOAD: begin
				ab_q  <= r_c_q << FRACTION_BITS;
				r_a_q <= WIDE_W'(tot_mag);
				r_b_q <= WIDE_W'(tot_mag);
				r_c_q <= '0;
			end
			OP_SUB: begin
				diff_pos_q <= (ab_q > r_c_q);
				ab_q       <= ab_q - r_c_q;
			end
			OP_ERR_ZERO: err_q <= '0;
			OP_ERR_DIV_LOAD: begin
				r_a_q <= ab_q;
				r_b_q <= n3_q;
				r_c_q <= '0;
			end
			OP_SQRT_LOAD: begin
				r_b_q <= WIDE_W'(1) << (WIDE_W - 2);
				r_c_q <= '0;
			end
			OP_SQRT_STEP: begin
				if (sqrt_ge) begin
					r_a_q <= r_a_q - sqrt_t;
					r_c_q <= (r_c_q >> 1) + r_b_q;
				end else begin
					r_c_q <= r_c_q >> 1;
				end
				r_b_q <= r_b_q >> 2;
			end
			OP_ERR_SET: err_q <= sat_mag(r_c_q[TOTAL_W-1:0], 1'b0);
			OP_OUT_LOAD: begin
				out_mean_q   <= mean_q;
				out_err_q    <= err_q;
				out_events_q <= count_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_mean   = out_mean_q;
	assign out_error  = out_err_q;
	assign out_events = out_events_q;

endmodule

`default_nettype wire
